### sv/asciip_pkg.sv
// Shared types, character codes and digit decode for the ASCII to uint64 parser.
// No dependencies; used by asciip_core and ascii_to_uint64_parser.
package asciip_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned BASE_W  = 6;
    localparam int unsigned DIGIT_W = 5;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;

    localparam logic [BASE_W-1:0] BASE_NONE = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    localparam logic [DIGIT_W-1:0] NOT_DIGIT = 5'd16;

    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_FIRST   = 3'd1,
        PH_ZERO    = 3'd2,
        PH_DIGITS  = 3'd3,
        PH_STOPPED = 3'd4
    } t_phase;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] character;
    } t_in_item;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        begin
            d = NOT_DIGIT;
            if (c inside {[CH_ZERO:CH_NINE]}) begin
                d = DIGIT_W'(c - CH_ZERO);
            end else if (c inside {[CH_LA:CH_LF]}) begin
                d = DIGIT_W'(c - CH_LA) + 5'd10;
            end else if (c inside {[CH_UA:CH_UF]}) begin
                d = DIGIT_W'(c - CH_UA) + 5'd10;
            end
            return d;
        end
    endfunction

endpackage

### sv/asciip_core.sv
// Parse state, per-character step logic and result register.
// Depends on asciip_pkg.
module asciip_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  asciip_pkg::t_in_item                  i_item,
    input  logic [asciip_pkg::BASE_W-1:0]         i_number_base,
    input  logic                                  i_stall,
    output logic                                  o_advance,
    output logic                                  o_valid,
    output logic [asciip_pkg::VALUE_W-1:0]        o_value
);

    logic [asciip_pkg::VALUE_W-1:0]   r_acc, n_acc;
    logic                             r_neg, n_neg;
    asciip_pkg::t_phase               r_phase, n_phase;
    logic [asciip_pkg::BASE_W-1:0]    r_base, n_base;
    logic                             r_out_valid, n_out_valid;
    logic [asciip_pkg::VALUE_W-1:0]   r_out_value, n_out_value;

    logic                             w_is_nul;
    logic                             w_first;
    logic                             w_take;
    logic [asciip_pkg::BASE_W-1:0]    w_take_base;
    logic [asciip_pkg::DIGIT_W-1:0]   w_digit;
    logic [asciip_pkg::VALUE_W+asciip_pkg::BASE_W-1:0] w_prod;
    logic [asciip_pkg::VALUE_W-1:0]   w_emit;

    assign w_is_nul  = (i_item.character == asciip_pkg::CH_NUL);
    assign o_advance = i_item.valid && (!w_is_nul || !r_out_valid || !i_stall);
    assign w_digit   = asciip_pkg::digit_of(i_item.character);
    assign w_prod    = (asciip_pkg::VALUE_W + asciip_pkg::BASE_W)'(r_acc)
                     * (asciip_pkg::VALUE_W + asciip_pkg::BASE_W)'(w_take_base);

    always_comb begin
        if (r_phase == asciip_pkg::PH_ZERO) begin
            w_emit = '0;
        end else if (r_neg) begin
            w_emit = '0 - r_acc;
        end else begin
            w_emit = r_acc;
        end
    end

    always_comb begin
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_phase     = r_phase;
        n_base      = r_base;
        w_first     = 1'b0;
        w_take      = 1'b0;
        w_take_base = r_base;

        if (!w_is_nul) begin
            case (r_phase)
                asciip_pkg::PH_START: begin
                    if (i_item.character == asciip_pkg::CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = asciip_pkg::PH_FIRST;
                    end else begin
                        w_first = 1'b1;
                    end
                end
                asciip_pkg::PH_FIRST: begin
                    w_first = 1'b1;
                end
                asciip_pkg::PH_ZERO: begin
                    if (i_item.character == asciip_pkg::CH_LX ||
                        i_item.character == asciip_pkg::CH_UX) begin
                        n_base  = asciip_pkg::BASE_HEX;
                        n_phase = asciip_pkg::PH_DIGITS;
                    end else begin
                        w_take_base = asciip_pkg::BASE_OCT;
                        n_base      = asciip_pkg::BASE_OCT;
                        w_take      = 1'b1;
                    end
                end
                asciip_pkg::PH_DIGITS: begin
                    w_take = 1'b1;
                end
                default: begin
                    n_phase = asciip_pkg::PH_STOPPED;
                end
            endcase

            if (w_first) begin
                if (i_number_base != asciip_pkg::BASE_NONE) begin
                    w_take_base = i_number_base;
                    n_base      = i_number_base;
                    w_take      = 1'b1;
                end else if (i_item.character == asciip_pkg::CH_ZERO) begin
                    n_phase = asciip_pkg::PH_ZERO;
                end else if (i_item.character inside
                             {[asciip_pkg::CH_ONE:asciip_pkg::CH_NINE]}) begin
                    w_take_base = asciip_pkg::BASE_DEC;
                    n_base      = asciip_pkg::BASE_DEC;
                    w_take      = 1'b1;
                end else begin
                    w_take_base = asciip_pkg::BASE_NONE;
                    n_base      = asciip_pkg::BASE_NONE;
                    w_take      = 1'b1;
                end
            end

            if (w_take) begin
                if (w_digit == asciip_pkg::NOT_DIGIT) begin
                    n_phase = asciip_pkg::PH_STOPPED;
                end else begin
                    n_phase = asciip_pkg::PH_DIGITS;
                    if (w_take_base == asciip_pkg::BASE_OCT) begin
                        n_acc = {r_acc[asciip_pkg::VALUE_W-4:0], 3'b000}
                              | asciip_pkg::VALUE_W'(w_digit);
                    end else if (w_take_base == asciip_pkg::BASE_HEX) begin
                        n_acc = {r_acc[asciip_pkg::VALUE_W-5:0], 4'b0000}
                              | asciip_pkg::VALUE_W'(w_digit);
                    end else begin
                        n_acc = w_prod[asciip_pkg::VALUE_W-1:0]
                              + asciip_pkg::VALUE_W'(w_digit);
                    end
                end
            end
        end else begin
            n_acc   = '0;
            n_neg   = 1'b0;
            n_phase = asciip_pkg::PH_START;
            n_base  = asciip_pkg::BASE_NONE;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        n_out_value = r_out_value;
        if (o_advance && w_is_nul) begin
            n_out_valid = 1'b1;
            n_out_value = w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_phase     <= asciip_pkg::PH_START;
            r_base      <= asciip_pkg::BASE_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_acc   <= n_acc;
                r_neg   <= n_neg;
                r_phase <= n_phase;
                r_base  <= n_base;
            end
            r_out_valid <= n_out_valid;
        end
        r_out_value <= n_out_value;
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;

endmodule

### sv/ascii_to_uint64_parser.sv
// Top level of the ASCII to uint64 parser: input register, base register, handshake.
// Depends on asciip_pkg and asciip_core.
//
// Characters transfer in one per clock while the input side does not stall; each one
// is held in the input register and then folded into the parse state by a shift-or
// (base 8 or 16) or a 64 by 6 bit multiply-add (any other base). A NUL terminator
// passes through the input register, yields the 64-bit value in the result register and
// resets the parse state, so the next string may follow at once. The input side
// stalls only while a NUL waits behind a result that the output side has not taken.
// Write number_base only between strings.
module ascii_to_uint64_parser (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic [asciip_pkg::CHAR_W-1:0]         i_character,
    output logic                                  o_stall,
    output logic                                  o_valid,
    output logic [asciip_pkg::VALUE_W-1:0]        o_value,
    input  logic                                  i_stall,
    input  logic                                  i_number_base_we,
    input  logic [asciip_pkg::BASE_W-1:0]         i_number_base
);

    logic                              r_in_valid;
    logic [asciip_pkg::CHAR_W-1:0]     r_in_char;
    logic [asciip_pkg::BASE_W-1:0]     r_number_base;
    asciip_pkg::t_in_item              w_item;
    logic                              w_advance;

    assign w_item.valid     = r_in_valid;
    assign w_item.character = r_in_char;
    assign o_stall          = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_number_base <= asciip_pkg::BASE_NONE;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (i_number_base_we) begin
                r_number_base <= i_number_base;
            end
        end
        if (!o_stall && i_valid) begin
            r_in_char <= i_character;
        end
    end

    asciip_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_item),
        .i_number_base (r_number_base),
        .i_stall       (i_stall),
        .o_advance     (w_advance),
        .o_valid       (o_valid),
        .o_value       (o_value)
    );

endmodule

### tb/tb_ascii_to_uint64_parser.sv
// Self-checking testbench for ascii_to_uint64_parser: character strings in, 64-bit values out.
// Depends on asciip_pkg and the ascii_to_uint64_parser RTL; predicts each value as strings
// transfer in and checks it against the result channel under random idling and stalls.
module tb_ascii_to_uint64_parser;

    localparam int unsigned IDLE_LIMIT  = 3000;
    localparam int unsigned PHASE_CHARS = 120;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic [asciip_pkg::CHAR_W-1:0]       i_character = '0;
    logic                                o_stall;
    logic                                o_valid;
    logic [asciip_pkg::VALUE_W-1:0]      o_value;
    logic                                i_stall = 1'b0;
    logic                                i_number_base_we = 1'b0;
    logic [asciip_pkg::BASE_W-1:0]       i_number_base = '0;

    logic [asciip_pkg::CHAR_W-1:0]       pending_chars[$];
    logic [asciip_pkg::VALUE_W-1:0]      expected_values[$];

    logic [asciip_pkg::BASE_W-1:0]       base_setting = asciip_pkg::BASE_NONE;
    logic [asciip_pkg::VALUE_W-1:0]      parse_acc = '0;
    logic                                parse_neg = 1'b0;
    asciip_pkg::t_phase                  parse_ph = asciip_pkg::PH_START;
    logic [asciip_pkg::BASE_W-1:0]       parse_base = asciip_pkg::BASE_NONE;

    logic                in_fired = 1'b0;
    logic                out_fired = 1'b0;
    int unsigned         drv_wait = 0;
    int unsigned         stall_left = 0;
    int unsigned         gap_max = 18;
    int unsigned         idle_cycles = 0;
    int unsigned         fail_count = 0;
    int unsigned         sent_chars = 0;
    int unsigned         taken_chars = 0;
    int unsigned         checked_values = 0;
    int unsigned         base_settings = 0;

    ascii_to_uint64_parser i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_character      (i_character),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .o_value          (o_value),
        .i_stall          (i_stall),
        .i_number_base_we (i_number_base_we),
        .i_number_base    (i_number_base)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [asciip_pkg::DIGIT_W-1:0] hex_value(
        input logic [asciip_pkg::CHAR_W-1:0] c);
        if (c >= asciip_pkg::CH_ZERO && c <= asciip_pkg::CH_NINE)
            return asciip_pkg::DIGIT_W'(c - asciip_pkg::CH_ZERO);
        if (c >= asciip_pkg::CH_LA && c <= asciip_pkg::CH_LF)
            return asciip_pkg::DIGIT_W'(c - asciip_pkg::CH_LA + 8'd10);
        if (c >= asciip_pkg::CH_UA && c <= asciip_pkg::CH_UF)
            return asciip_pkg::DIGIT_W'(c - asciip_pkg::CH_UA + 8'd10);
        return asciip_pkg::NOT_DIGIT;
    endfunction

    task automatic add_digit(input logic [asciip_pkg::CHAR_W-1:0] c);
        logic [asciip_pkg::DIGIT_W-1:0] d;
        d = hex_value(c);
        if (d == asciip_pkg::NOT_DIGIT) begin
            parse_ph = asciip_pkg::PH_STOPPED;
        end else begin
            if (parse_base == asciip_pkg::BASE_OCT) begin
                parse_acc = {parse_acc[asciip_pkg::VALUE_W-4:0], 3'b000}
                          | asciip_pkg::VALUE_W'(d);
            end else if (parse_base == asciip_pkg::BASE_HEX) begin
                parse_acc = {parse_acc[asciip_pkg::VALUE_W-5:0], 4'b0000}
                          | asciip_pkg::VALUE_W'(d);
            end else begin
                parse_acc = parse_acc * asciip_pkg::VALUE_W'(parse_base)
                          + asciip_pkg::VALUE_W'(d);
            end
            parse_ph = asciip_pkg::PH_DIGITS;
        end
    endtask

    task automatic open_number(input logic [asciip_pkg::CHAR_W-1:0] c);
        if (base_setting != asciip_pkg::BASE_NONE) begin
            parse_base = base_setting;
            add_digit(c);
        end else if (c == asciip_pkg::CH_ZERO) begin
            parse_ph = asciip_pkg::PH_ZERO;
        end else if (c >= asciip_pkg::CH_ONE && c <= asciip_pkg::CH_NINE) begin
            parse_base = asciip_pkg::BASE_DEC;
            add_digit(c);
        end else begin
            parse_base = asciip_pkg::BASE_NONE;
            add_digit(c);
        end
    endtask

    task automatic fold_char(input logic [asciip_pkg::CHAR_W-1:0] c);
        logic [asciip_pkg::VALUE_W-1:0] v;
        if (c == asciip_pkg::CH_NUL) begin
            v = parse_acc;
            if (parse_ph == asciip_pkg::PH_ZERO) begin
                v = '0;
            end else if (parse_neg) begin
                v = -v;
            end
            expected_values.push_back(v);
            parse_acc  = '0;
            parse_neg  = 1'b0;
            parse_ph   = asciip_pkg::PH_START;
            parse_base = asciip_pkg::BASE_NONE;
        end else begin
            case (parse_ph)
                asciip_pkg::PH_START: begin
                    if (c == asciip_pkg::CH_MINUS) begin
                        parse_neg = 1'b1;
                        parse_ph  = asciip_pkg::PH_FIRST;
                    end else begin
                        open_number(c);
                    end
                end
                asciip_pkg::PH_FIRST: open_number(c);
                asciip_pkg::PH_ZERO: begin
                    if (c == asciip_pkg::CH_LX || c == asciip_pkg::CH_UX) begin
                        parse_base = asciip_pkg::BASE_HEX;
                        parse_ph   = asciip_pkg::PH_DIGITS;
                    end else begin
                        parse_base = asciip_pkg::BASE_OCT;
                        add_digit(c);
                    end
                end
                asciip_pkg::PH_DIGITS: add_digit(c);
                default: parse_ph = asciip_pkg::PH_STOPPED;
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        logic [asciip_pkg::VALUE_W-1:0] want;
        if (!i_rst_n) begin
            in_fired  <= 1'b0;
            out_fired <= 1'b0;
        end else begin
            in_fired  <= i_valid && !o_stall;
            out_fired <= o_valid && !i_stall;
            if (i_number_base_we) begin
                base_setting = i_number_base;
            end
            if (o_valid && !i_stall) begin
                checked_values++;
                if (expected_values.size() == 0) begin
                    $error("value: no result expected, got %h", o_value);
                    fail_count++;
                end else begin
                    want = expected_values.pop_front();
                    if (o_value !== want) begin
                        $error("value: expected %h, got %h", want, o_value);
                        fail_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                taken_chars++;
                fold_char(i_character);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (in_fired || !i_valid)) begin
            if (drv_wait != 0) begin
                drv_wait <= drv_wait - 1;
                i_valid  <= 1'b0;
            end else if (pending_chars.size() != 0) begin
                i_valid     <= 1'b1;
                i_character <= pending_chars.pop_front();
                drv_wait    <= $urandom_range(0, gap_max);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        int unsigned s;
        s = out_fired ? $urandom_range(0, gap_max) : stall_left;
        if (s != 0) begin
            i_stall    <= 1'b1;
            stall_left <= s - 1;
        end else begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end
    end

    task automatic send(input logic [asciip_pkg::CHAR_W-1:0] c);
        pending_chars.push_back(c);
        sent_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send(s[i]);
        end
        send(asciip_pkg::CH_NUL);
    endtask

    function automatic logic [asciip_pkg::CHAR_W-1:0] pick_digit(input int unsigned span);
        int unsigned d;
        d = $urandom_range(0, span - 1);
        if (d < 10) return asciip_pkg::CH_ZERO + asciip_pkg::CHAR_W'(d);
        return ($urandom_range(0, 1) ? asciip_pkg::CH_LA : asciip_pkg::CH_UA)
             + asciip_pkg::CHAR_W'(d - 10);
    endfunction

    function automatic logic [asciip_pkg::CHAR_W-1:0] pick_junk();
        logic [asciip_pkg::CHAR_W-1:0] c;
        c = asciip_pkg::CHAR_W'($urandom_range(1, 255));
        while (hex_value(c) != asciip_pkg::NOT_DIGIT) begin
            c = asciip_pkg::CHAR_W'($urandom_range(1, 255));
        end
        return c;
    endfunction

    task automatic send_digits(input int unsigned n, input int unsigned span);
        for (int unsigned i = 0; i < n; i++) begin
            send(pick_digit(span));
        end
    endtask

    task automatic send_random_string();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if ($urandom_range(0, 9) < 3) begin
            send(asciip_pkg::CH_MINUS);
        end
        case (kind)
            0: begin
                repeat ($urandom_range(0, 8))
                    send(asciip_pkg::CHAR_W'($urandom_range(1, 255)));
            end
            1: begin
                send(asciip_pkg::CH_ZERO);
                send($urandom_range(0, 1) ? asciip_pkg::CH_LX : asciip_pkg::CH_UX);
                send_digits($urandom_range(0, 17), 16);
            end
            2: begin
                send(asciip_pkg::CH_ZERO);
                send_digits($urandom_range(0, 22), $urandom_range(0, 3) ? 8 : 16);
            end
            3, 4, 5: begin
                send(asciip_pkg::CH_ONE + asciip_pkg::CHAR_W'($urandom_range(0, 8)));
                send_digits($urandom_range(0, 21), $urandom_range(0, 3) ? 10 : 16);
            end
            6: begin
                if ($urandom_range(0, 1)) begin
                    send(pick_junk());
                end else begin
                    send(pick_digit(16) | 8'h40);
                end
                send_digits($urandom_range(0, 6), 16);
            end
            7: begin
                send(asciip_pkg::CH_MINUS);
                send_digits($urandom_range(0, 5), 10);
            end
            default: send_digits($urandom_range(0, 20), 16);
        endcase
        if ($urandom_range(0, 4) == 0) begin
            send(pick_junk());
            repeat ($urandom_range(0, 4))
                send(asciip_pkg::CHAR_W'($urandom_range(1, 255)));
        end
        send(asciip_pkg::CH_NUL);
    endtask

    task automatic write_number_base(input logic [asciip_pkg::BASE_W-1:0] v);
        @(negedge i_clk);
        i_number_base_we <= 1'b1;
        i_number_base    <= v;
        @(negedge i_clk);
        i_number_base_we <= 1'b0;
        base_settings++;
    endtask

    task automatic drain();
        while (pending_chars.size() != 0 || i_valid || expected_values.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        logic [asciip_pkg::BASE_W-1:0] bases[11];
        int unsigned                   start;
        bases = '{6'd0, 6'd10, 6'd16, 6'd8, 6'd1, 6'd2, 6'd36, 6'd37, 6'd63, 6'd0, 6'd0};
        bases[9] = asciip_pkg::BASE_W'($urandom_range(0, 63));
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_number_base(asciip_pkg::BASE_NONE);
        send_text("");
        send_text("0");
        send_text("-0");
        send_text("0x");
        send_text("0X1f");
        send_text("-a5");
        send_text("09");
        send_text("1z7");
        drain();

        for (int p = 0; p < 11; p++) begin
            gap_max = (p % 3 == 2) ? 0 : 18;
            write_number_base(bases[p]);
            start = sent_chars;
            while (sent_chars - start < PHASE_CHARS) begin
                send_random_string();
            end
            drain();
        end
        repeat (8) @(negedge i_clk);

        $display("Covered %0d characters and %0d parsed values over %0d radix settings",
                 taken_chars, checked_values, base_settings);
        if (fail_count == 0 && expected_values.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
